### hw/rtl/ptrc_pkg.sv
// shared types and constants of the point transform and range clip block
`timescale 1ns / 1ps

package ptrc_pkg;

  // coordinate format: signed Q13.10 metres
  localparam int CW = 24;
  // rotation entries: signed Q1.14, three to a row
  localparam int RFB = 14;
  localparam int RE = 16;
  localparam int ROW_W = 3 * RE;
  localparam int MAX_W = CW - 1;

  // internal widths
  localparam int LSQ_W = 2 * CW;          // squared norm
  localparam int MSQ_W = 2 * MAX_W;       // squared range limit
  localparam int SQ_RW = CW + 2;          // square root remainder
  localparam int NUM_W = CW + MAX_W;      // magnitude times range limit
  localparam int PROD_W = RE + CW;        // matrix entry times coordinate
  localparam int SUM_W = PROD_W + 2;      // sum of three products
  localparam int SH_W = SUM_W - RFB;      // sum after dropping the fraction
  localparam int ACC_W = SH_W + 1;        // plus offset

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = ROW_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW0       = 3'd0,
    CFG_ROT_ROW1       = 3'd1,
    CFG_ROT_ROW2       = 3'd2,
    CFG_OFFSET_X       = 3'd3,
    CFG_OFFSET_Y       = 3'd4,
    CFG_OFFSET_Z       = 3'd5,
    CFG_MAX_RAY_LENGTH = 3'd6
  } cfg_reg_t;

  // identity matrix after reset
  localparam logic [ROW_W-1:0] ROT_ROW0_RST = ROW_W'(48'h0000_0000_4000);
  localparam logic [ROW_W-1:0] ROT_ROW1_RST = ROW_W'(48'h0000_4000_0000);
  localparam logic [ROW_W-1:0] ROT_ROW2_RST = ROW_W'(48'h4000_0000_0000);

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic                 point_finite;
  } point_t;

  typedef struct packed {
    logic signed [CW-1:0] world_x;
    logic signed [CW-1:0] world_y;
    logic signed [CW-1:0] world_z;
    logic                 clipped;
  } world_t;

endpackage

### hw/rtl/point_transform_range_clip_unit.sv
// top level: range clip and rigid body transform of sensor points
`timescale 1ns / 1ps

// point_transform_range_clip_unit
//
// point channel: one sensor-frame point per beat (point_valid / point_stall).
// beats whose point_finite is clear are taken and dropped, no result.
// world channel: one world-frame point per result beat, clipped marks a
// clearing point that was pulled back onto max_ray_length first.
// cfg channel: register index and data, taken whenever cfg_valid is high
// (cfg_ready is tied high); write only while no point is in flight.
// throughput: one point per cycle unless world_stall holds the pipe; the square root
// (24 stages, one root bit each) and the three dividers (24 stages, one quotient
// bit each) are fully pipelined.
// stall: the whole pipe advances together; while a world beat waits under
// world_stall the pipe freezes and point_stall is raised, nothing is lost.
// reset: synchronous, clears all stage valid bits, loads the identity
// matrix, zero offsets and no range limit.

module point_transform_range_clip_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                point_valid,
  output logic                                point_stall,
  input  ptrc_pkg::point_t                    point,
  output logic                                world_valid,
  input  logic                                world_stall,
  output ptrc_pkg::world_t                    world,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = ptrc_pkg::CW;
  localparam int NS = ptrc_pkg::CW;  // root bits and quotient bits

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0][ptrc_pkg::ROW_W-1:0] rot;
  logic [2:0][CW-1:0]              offset;
  logic [ptrc_pkg::MAX_W-1:0]      max_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]  <= ptrc_pkg::ROT_ROW0_RST;
      rot[1]  <= ptrc_pkg::ROT_ROW1_RST;
      rot[2]  <= ptrc_pkg::ROT_ROW2_RST;
      offset  <= '0;
      max_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (ptrc_pkg::cfg_reg_t'(cfg_index))
        ptrc_pkg::CFG_ROT_ROW0:       rot[0] <= cfg_data;
        ptrc_pkg::CFG_ROT_ROW1:       rot[1] <= cfg_data;
        ptrc_pkg::CFG_ROT_ROW2:       rot[2] <= cfg_data;
        ptrc_pkg::CFG_OFFSET_X:       offset[0] <= cfg_data[CW-1:0];
        ptrc_pkg::CFG_OFFSET_Y:       offset[1] <= cfg_data[CW-1:0];
        ptrc_pkg::CFG_OFFSET_Z:       offset[2] <= cfg_data[CW-1:0];
        ptrc_pkg::CFG_MAX_RAY_LENGTH: max_len <= cfg_data[ptrc_pkg::MAX_W-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipe advance: everything moves unless a finished beat is held
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv         = !world_valid || !world_stall;
  assign point_stall = !adv;

  // stage 0: input register, non-finite points enter as bubbles
  logic               vld0;
  logic [2:0][CW-1:0] p0;

  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else if (adv) vld0 <= point_valid && point.point_finite;
    if (adv) begin
      p0[0] <= point.point_x;
      p0[1] <= point.point_y;
      p0[2] <= point.point_z;
    end
  end

  // stage 1: squares of magnitudes and of the range limit
  logic                             vld1;
  logic [2:0][CW-1:0]               p1;
  logic [2:0][ptrc_pkg::LSQ_W-1:0]  sq1;
  logic [ptrc_pkg::MSQ_W-1:0]       msq1;
  logic [2:0][CW-1:0]               mag0;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag0[a] = p0[a][CW-1] ? CW'(-p0[a]) : p0[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else if (adv) vld1 <= vld0;
    if (adv) begin
      p1 <= p0;
      for (int a = 0; a < 3; a++) begin
        sq1[a] <= ptrc_pkg::LSQ_W'(mag0[a]) * ptrc_pkg::LSQ_W'(mag0[a]);
      end
      msq1 <= ptrc_pkg::MSQ_W'(max_len) * ptrc_pkg::MSQ_W'(max_len);
    end
  end

  // stage 2: squared norm and range decision (on the limit is a hit)
  logic                        vld2;
  logic                        clip2;
  logic [2:0][CW-1:0]          p2;
  logic [ptrc_pkg::LSQ_W-1:0]  len2;
  logic [ptrc_pkg::LSQ_W-1:0]  len1;

  assign len1 = sq1[0] + sq1[1] + sq1[2];

  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else if (adv) vld2 <= vld1;
    if (adv) begin
      p2    <= p1;
      len2  <= len1;
      clip2 <= (msq1 != '0) && (len1 > ptrc_pkg::LSQ_W'(msq1));
    end
  end

  // ---------------------------------------------------------------------------
  // square root: one root bit per stage, two radicand bits shifted in
  // ---------------------------------------------------------------------------
  logic                       sq_vld  [NS];
  logic                       sq_clip [NS];
  logic [2:0][CW-1:0]         sq_p    [NS];
  logic [ptrc_pkg::LSQ_W-1:0] sq_rad  [NS];
  logic [ptrc_pkg::SQ_RW-1:0] sq_rem  [NS];
  logic [CW-1:0]              sq_root [NS];

  logic [ptrc_pkg::LSQ_W-1:0] sq_rad_next  [NS];
  logic [ptrc_pkg::SQ_RW-1:0] sq_rem_next  [NS];
  logic [CW-1:0]              sq_root_next [NS];

  always_comb begin
    logic [ptrc_pkg::LSQ_W-1:0] rad_in;
    logic [ptrc_pkg::SQ_RW-1:0] rem_in;
    logic [CW-1:0]              root_in;
    logic [ptrc_pkg::SQ_RW+1:0] rp;
    logic [ptrc_pkg::SQ_RW+1:0] trial;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rad_in  = len2;
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = sq_rad[k-1];
        rem_in  = sq_rem[k-1];
        root_in = sq_root[k-1];
      end
      rp    = {rem_in, rad_in[ptrc_pkg::LSQ_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      sq_rad_next[k] = {rad_in[ptrc_pkg::LSQ_W-3:0], 2'b00};
      if (rp >= trial) begin
        sq_rem_next[k]  = ptrc_pkg::SQ_RW'(rp - trial);
        sq_root_next[k] = {root_in[CW-2:0], 1'b1};
      end else begin
        sq_rem_next[k]  = rp[ptrc_pkg::SQ_RW-1:0];
        sq_root_next[k] = {root_in[CW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rst) sq_vld[k] <= 1'b0;
      else if (adv) sq_vld[k] <= (k == 0) ? vld2 : sq_vld[k-1];
      if (adv) begin
        sq_clip[k] <= (k == 0) ? clip2 : sq_clip[k-1];
        sq_p[k]    <= (k == 0) ? p2 : sq_p[k-1];
        sq_rad[k]  <= sq_rad_next[k];
        sq_rem[k]  <= sq_rem_next[k];
        sq_root[k] <= sq_root_next[k];
      end
    end
  end

  // numerator stage: magnitude times range limit per axis
  logic                            nm_vld;
  logic                            nm_clip;
  logic [2:0][CW-1:0]              nm_p;
  logic [CW-1:0]                   nm_s;
  logic [2:0][ptrc_pkg::NUM_W-1:0] nm_num;
  logic [2:0][CW-1:0]              mag_s;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_s[a] = sq_p[NS-1][a][CW-1] ? CW'(-sq_p[NS-1][a]) : sq_p[NS-1][a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) nm_vld <= 1'b0;
    else if (adv) nm_vld <= sq_vld[NS-1];
    if (adv) begin
      nm_clip <= sq_clip[NS-1];
      nm_p    <= sq_p[NS-1];
      nm_s    <= sq_root[NS-1];
      for (int a = 0; a < 3; a++) begin
        nm_num[a] <= ptrc_pkg::NUM_W'(mag_s[a]) * ptrc_pkg::NUM_W'(max_len);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // three restoring dividers, one quotient bit per stage; the quotient never
  // exceeds the magnitude, so the top numerator bits start as remainder
  // ---------------------------------------------------------------------------
  logic               dv_vld  [NS];
  logic               dv_clip [NS];
  logic [2:0][CW-1:0] dv_p    [NS];
  logic [CW-1:0]      dv_s    [NS];
  logic [2:0][CW-1:0] dv_rem  [NS];
  logic [2:0][CW-1:0] dv_low  [NS];
  logic [2:0][CW-1:0] dv_q    [NS];

  logic [2:0][CW-1:0] dv_rem_next [NS];
  logic [2:0][CW-1:0] dv_low_next [NS];
  logic [2:0][CW-1:0] dv_q_next   [NS];

  always_comb begin
    logic [CW-1:0] s_in;
    logic [CW-1:0] rem_in;
    logic [CW-1:0] low_in;
    logic [CW-1:0] q_in;
    logic [CW:0]   rp;
    for (int k = 0; k < NS; k++) begin
      s_in = (k == 0) ? nm_s : dv_s[k-1];
      for (int a = 0; a < 3; a++) begin
        if (k == 0) begin
          rem_in = CW'(nm_num[a][ptrc_pkg::NUM_W-1:CW]);
          low_in = nm_num[a][CW-1:0];
          q_in   = '0;
        end else begin
          rem_in = dv_rem[k-1][a];
          low_in = dv_low[k-1][a];
          q_in   = dv_q[k-1][a];
        end
        rp = {rem_in, low_in[CW-1]};
        dv_low_next[k][a] = {low_in[CW-2:0], 1'b0};
        if (rp >= {1'b0, s_in}) begin
          dv_rem_next[k][a] = CW'(rp - {1'b0, s_in});
          dv_q_next[k][a]   = {q_in[CW-2:0], 1'b1};
        end else begin
          dv_rem_next[k][a] = rp[CW-1:0];
          dv_q_next[k][a]   = {q_in[CW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rst) dv_vld[k] <= 1'b0;
      else if (adv) dv_vld[k] <= (k == 0) ? nm_vld : dv_vld[k-1];
      if (adv) begin
        dv_clip[k] <= (k == 0) ? nm_clip : dv_clip[k-1];
        dv_p[k]    <= (k == 0) ? nm_p : dv_p[k-1];
        dv_s[k]    <= (k == 0) ? nm_s : dv_s[k-1];
        dv_rem[k]  <= dv_rem_next[k];
        dv_low[k]  <= dv_low_next[k];
        dv_q[k]    <= dv_q_next[k];
      end
    end
  end

  // select stage: clipped points take the signed quotient
  logic               se_vld;
  logic               se_clip;
  logic [2:0][CW-1:0] se_p;

  always_ff @(posedge clk) begin
    if (rst) se_vld <= 1'b0;
    else if (adv) se_vld <= dv_vld[NS-1];
    if (adv) begin
      se_clip <= dv_clip[NS-1];
      for (int a = 0; a < 3; a++) begin
        if (!dv_clip[NS-1]) se_p[a] <= dv_p[NS-1][a];
        else if (dv_p[NS-1][a][CW-1]) se_p[a] <= CW'(-dv_q[NS-1][a]);
        else se_p[a] <= dv_q[NS-1][a];
      end
    end
  end

  // product stage: nine signed products
  logic                                  pr_vld;
  logic                                  pr_clip;
  logic signed [ptrc_pkg::PROD_W-1:0]    pr [3][3];

  always_ff @(posedge clk) begin
    if (rst) pr_vld <= 1'b0;
    else if (adv) pr_vld <= se_vld;
    if (adv) begin
      pr_clip <= se_clip;
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          pr[a][c] <= ptrc_pkg::PROD_W'($signed(rot[a][ptrc_pkg::RE*c +: ptrc_pkg::RE]))
                    * ptrc_pkg::PROD_W'($signed(se_p[c]));
        end
      end
    end
  end

  // sum stage: round half up, drop fraction bits
  logic                              su_vld;
  logic                              su_clip;
  logic signed [ptrc_pkg::SH_W-1:0]  su [3];
  logic signed [ptrc_pkg::SUM_W-1:0] sum [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = ptrc_pkg::SUM_W'(pr[a][0]) + ptrc_pkg::SUM_W'(pr[a][1])
             + ptrc_pkg::SUM_W'(pr[a][2])
             + (ptrc_pkg::SUM_W'(1) <<< (ptrc_pkg::RFB - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) su_vld <= 1'b0;
    else if (adv) su_vld <= pr_vld;
    if (adv) begin
      su_clip <= pr_clip;
      for (int a = 0; a < 3; a++) begin
        su[a] <= sum[a][ptrc_pkg::SUM_W-1:ptrc_pkg::RFB];
      end
    end
  end

  // output stage: add offset, saturate
  localparam logic signed [ptrc_pkg::ACC_W-1:0] HI = ptrc_pkg::ACC_W'((1 << (CW - 1)) - 1);
  localparam logic signed [ptrc_pkg::ACC_W-1:0] LO = -HI - ptrc_pkg::ACC_W'(1);

  logic signed [ptrc_pkg::ACC_W-1:0] acc [3];
  logic [2:0][CW-1:0]                sat;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc[a] = ptrc_pkg::ACC_W'(su[a]) + ptrc_pkg::ACC_W'($signed(offset[a]));
      if (acc[a] > HI) sat[a] = HI[CW-1:0];
      else if (acc[a] < LO) sat[a] = LO[CW-1:0];
      else sat[a] = acc[a][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) world_valid <= 1'b0;
    else if (adv) world_valid <= su_vld;
    if (adv) begin
      world.world_x <= sat[0];
      world.world_y <= sat[1];
      world.world_z <= sat[2];
      world.clipped <= su_clip;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_reset_empty : assert property (@(posedge clk) rst |=> !world_valid)
    else $error("result beat right after reset");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    point_stall |-> (world_valid && world_stall))
    else $error("input stalled without a held result");

  a_pipe_frozen : assert property (@(posedge clk) disable iff (rst)
    (world_valid && world_stall) |=> ($stable(vld0) && $stable(su_vld)))
    else $error("pipe moved while result held");

endmodule

### tb/point_transform_range_clip_unit_tb.sv
// testbench of the point transform and range clip unit
`timescale 1ns / 1ps

// queue of predicted world beats, checked in order against the block
class world_scoreboard;
  ptrc_pkg::world_t pending_world[$];
  int unsigned failures;
  int unsigned matched;

  function void note_point(ptrc_pkg::world_t w);
    pending_world = {pending_world, w};
  endfunction

  function void check_world(ptrc_pkg::world_t got);
    ptrc_pkg::world_t want;
    if (pending_world.size() == 0) begin
      $error("world beat with nothing expected: %h", got);
      failures++;
      return;
    end
    want = pending_world.pop_front();
    matched++;
    if (got.world_x !== want.world_x) begin
      $error("world_x expected %0d actual %0d", want.world_x, got.world_x);
      failures++;
    end
    if (got.world_y !== want.world_y) begin
      $error("world_y expected %0d actual %0d", want.world_y, got.world_y);
      failures++;
    end
    if (got.world_z !== want.world_z) begin
      $error("world_z expected %0d actual %0d", want.world_z, got.world_z);
      failures++;
    end
    if (got.clipped !== want.clipped) begin
      $error("clipped expected %0b actual %0b", want.clipped, got.clipped);
      failures++;
    end
  endfunction
endclass

module point_transform_range_clip_unit_tb;

  localparam int CW = ptrc_pkg::CW;
  localparam int RE = ptrc_pkg::RE;
  localparam int RFB = ptrc_pkg::RFB;
  localparam int ROW_W = ptrc_pkg::ROW_W;
  localparam int MAX_W = ptrc_pkg::MAX_W;
  localparam int CFG_IDX_W = ptrc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = ptrc_pkg::CFG_DATA_W;

  localparam int LATENCY = 56;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_stall;
  ptrc_pkg::point_t point = '0;
  logic world_valid;
  logic world_stall = 1'b0;
  ptrc_pkg::world_t world;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  point_transform_range_clip_unit DUT (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .world_valid(world_valid), .world_stall(world_stall), .world(world),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shadow copy of the register file
  logic [ROW_W-1:0] mat_row[3];
  logic signed [CW-1:0] pose_off[3];
  logic [MAX_W-1:0] range_limit;

  world_scoreboard sb;
  longint cycles = 0;
  int unsigned points_sent = 0;
  int unsigned points_dropped = 0;
  int unsigned points_clipped = 0;
  int unsigned cfg_writes = 0;
  bit stim_done = 1'b0;

  // integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // one world axis: row dot point, round half up, add offset, saturate
  function automatic logic signed [CW-1:0] rotate_axis(logic [ROW_W-1:0] row,
      logic signed [CW-1:0] off, longint p[3]);
    longint acc, hi, lo;
    logic signed [RE-1:0] e;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      e = row[c*RE +: RE];
      acc += longint'(e) * p[c];
    end
    acc += longint'(1) <<< (RFB - 1);
    acc = acc >>> RFB;
    acc += longint'(off);
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (acc > hi) acc = hi;
    if (acc < lo) acc = lo;
    return acc[CW-1:0];
  endfunction

  // world point predicted for a finite sensor point
  function automatic ptrc_pkg::world_t predict_world(ptrc_pkg::point_t pt);
    ptrc_pkg::world_t w;
    longint p[3];
    longint unsigned len_sq, lim, root, q, m;
    p[0] = longint'(pt.point_x);
    p[1] = longint'(pt.point_y);
    p[2] = longint'(pt.point_z);
    len_sq = 0;
    for (int i = 0; i < 3; i++) len_sq += longint'(p[i] * p[i]);
    lim = range_limit;
    w.clipped = 1'b0;
    if (lim != 0 && len_sq > lim * lim) begin
      w.clipped = 1'b1;
      root = floor_sqrt(len_sq);
      if (root == 0) root = 1;
      for (int i = 0; i < 3; i++) begin
        m = (p[i] < 0) ? -p[i] : p[i];
        q = (m * lim) / root;
        p[i] = (p[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    w.world_x = rotate_axis(mat_row[0], pose_off[0], p);
    w.world_y = rotate_axis(mat_row[1], pose_off[1], p);
    w.world_z = rotate_axis(mat_row[2], pose_off[2], p);
    return w;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // global cycle counter and timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // input and output beats are both observed at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && !point_stall) begin
        if (point.point_finite) begin
          ptrc_pkg::world_t w;
          w = predict_world(point);
          if (w.clipped) points_clipped++;
          sb.note_point(w);
        end else begin
          points_dropped++;
        end
      end
      if (world_valid && !world_stall) sb.check_world(world);
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          ptrc_pkg::CFG_ROT_ROW0:       mat_row[0] <= cfg_data;
          ptrc_pkg::CFG_ROT_ROW1:       mat_row[1] <= cfg_data;
          ptrc_pkg::CFG_ROT_ROW2:       mat_row[2] <= cfg_data;
          ptrc_pkg::CFG_OFFSET_X:       pose_off[0] <= cfg_data[CW-1:0];
          ptrc_pkg::CFG_OFFSET_Y:       pose_off[1] <= cfg_data[CW-1:0];
          ptrc_pkg::CFG_OFFSET_Z:       pose_off[2] <= cfg_data[CW-1:0];
          ptrc_pkg::CFG_MAX_RAY_LENGTH: range_limit <= cfg_data[MAX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // receiver side: random stall pattern, with calm stretches
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if ($urandom_range(0, 9) < 2) begin
        world_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end
      g = stim_done ? 0 : gap_len();
      if (g != 0) begin
        world_stall <= 1'b1;
        repeat (g) @(negedge clk);
      end
      world_stall <= 1'b0;
      @(negedge clk);
    end
  end

  // one register write, taken when ready is seen high; valid stays up so
  // writes can follow back to back, the caller drops it after the last one
  task automatic write_reg(ptrc_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drains the pipe ahead of a whole register set; the pipe must be empty first
  task automatic drain_pipe();
    while (sb.pending_world.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // present one point beat and hold it until taken
  task automatic send_point(ptrc_pkg::point_t pt, bit allow_gap);
    int g;
    if (allow_gap) begin
      g = gap_len();
      if (g != 0) begin
        point_valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
    point_valid <= 1'b1;
    point <= pt;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    points_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      1: return CW'(int'($urandom_range(0, 8000)) - 4000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic ptrc_pkg::point_t rand_point();
    ptrc_pkg::point_t pt;
    int mode;
    mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    pt.point_x = ($urandom_range(0, 9) == 0) ? rand_coord(0) : rand_coord(mode);
    pt.point_y = rand_coord(mode);
    pt.point_z = ($urandom_range(0, 9) == 0) ? rand_coord(0) : rand_coord(mode);
    pt.point_finite = ($urandom_range(0, 9) != 0);
    return pt;
  endfunction

  // random rotation rows: a signed unit entry on the diagonal, bounded random entries, and raw noise
  function automatic logic [ROW_W-1:0] rand_row(int r);
    logic [ROW_W-1:0] row;
    case ($urandom_range(0, 2))
      0: begin
        row = '0;
        row[r*RE +: RE] = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
      end
      1: row = {16'($urandom_range(0, 32767) - 16384),
                16'($urandom_range(0, 32767) - 16384),
                16'($urandom_range(0, 32767) - 16384)};
      default: row = ROW_W'({$urandom, $urandom});
    endcase
    return row;
  endfunction

  task automatic random_settings(int phase);
    write_reg(ptrc_pkg::CFG_ROT_ROW0, rand_row(0));
    write_reg(ptrc_pkg::CFG_ROT_ROW1, rand_row(1));
    write_reg(ptrc_pkg::CFG_ROT_ROW2, rand_row(2));
    write_reg(ptrc_pkg::CFG_OFFSET_X, CFG_DATA_W'((phase % 3 == 0) ?
              {1'b0, {(CW-1){1'b1}}} : CW'($urandom)));
    write_reg(ptrc_pkg::CFG_OFFSET_Y, CFG_DATA_W'((phase % 3 == 1) ?
              {1'b1, {(CW-1){1'b0}}} : CW'($urandom)));
    write_reg(ptrc_pkg::CFG_OFFSET_Z,
              CFG_DATA_W'(CW'(int'($urandom_range(0, 4000)) - 2000)));
    case (phase % 4)
      0: write_reg(ptrc_pkg::CFG_MAX_RAY_LENGTH, '0);
      1: write_reg(ptrc_pkg::CFG_MAX_RAY_LENGTH, CFG_DATA_W'({MAX_W{1'b1}}));
      2: write_reg(ptrc_pkg::CFG_MAX_RAY_LENGTH,
                   CFG_DATA_W'($urandom_range(1, 3000)));
      default: write_reg(ptrc_pkg::CFG_MAX_RAY_LENGTH, CFG_DATA_W'(MAX_W'($urandom)));
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    ptrc_pkg::point_t pt;
    sb = new();
    mat_row[0] = ptrc_pkg::ROT_ROW0_RST;
    mat_row[1] = ptrc_pkg::ROT_ROW1_RST;
    mat_row[2] = ptrc_pkg::ROT_ROW2_RST;
    pose_off = '{default: '0};
    range_limit = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity pose, no limit, extremes and non-finite beats
    pt = '{point_x: {1'b0, {(CW-1){1'b1}}}, point_y: {1'b1, {(CW-1){1'b0}}},
           point_z: '0, point_finite: 1'b1};
    send_point(pt, 0);
    pt = '{point_x: '1, point_y: 24'sd1, point_z: {1'b1, {(CW-1){1'b0}}},
           point_finite: 1'b1};
    send_point(pt, 0);
    pt.point_finite = 1'b0;
    send_point(pt, 0);
    pt = '0;
    send_point(pt, 0);
    point_valid <= 1'b0;
    drain_pipe();

    // limit of 3 m, points on and beyond it; offset pushes saturation
    write_reg(ptrc_pkg::CFG_MAX_RAY_LENGTH, CFG_DATA_W'(3 * 1024));
    write_reg(ptrc_pkg::CFG_OFFSET_X, CFG_DATA_W'({1'b0, {(CW-1){1'b1}}}));
    write_reg(ptrc_pkg::CFG_OFFSET_Y, CFG_DATA_W'({1'b1, {(CW-1){1'b0}}}));
    cfg_valid <= 1'b0;
    pt = '{point_x: 24'sd3072, point_y: '0, point_z: '0, point_finite: 1'b1};
    send_point(pt, 0); // exactly on the limit: a hit
    pt.point_x = 24'sd3073;
    send_point(pt, 0); // just beyond
    pt = '{point_x: -24'sd1843, point_y: 24'sd2458, point_z: 24'sd0, point_finite: 1'b1};
    send_point(pt, 0); // 3-4-5 a hair beyond the limit
    pt = '{point_x: {1'b1, {(CW-1){1'b0}}}, point_y: {1'b1, {(CW-1){1'b0}}},
           point_z: {1'b0, {(CW-1){1'b1}}}, point_finite: 1'b1};
    send_point(pt, 0);
    pt = '{point_x: -24'sd5000, point_y: 24'sd7, point_z: -24'sd12000, point_finite: 1'b1};
    send_point(pt, 0);
    point_valid <= 1'b0;
    drain_pipe();

    // out-of-range index must be ignored
    write_reg(ptrc_pkg::cfg_reg_t'(3'd7), '1);

    // random phases, each with its own register set
    for (int phase = 0; phase < 12; phase++) begin
      random_settings(phase);
      for (int i = 0; i < 150; i++) send_point(rand_point(), 1);
      point_valid <= 1'b0;
      drain_pipe();
    end

    stim_done = 1'b1;
    repeat (LATENCY + 10) @(negedge clk);
    $display("sent %0d points (%0d non-finite, %0d clipped), %0d register writes",
             points_sent, points_dropped, points_clipped, cfg_writes);
    $display("checked %0d world beats", sb.matched);
    if (sb.pending_world.size() != 0) begin
      $error("%0d world beats never arrived", sb.pending_world.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### point_transform_range_clip_unit.f
hw/rtl/ptrc_pkg.sv
hw/rtl/point_transform_range_clip_unit.sv
tb/point_transform_range_clip_unit_tb.sv
